FILE: src/tga_rle_pixel_decoder_unit_defines.svh
// Assertion helpers shared by the parser and queue modules.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tga decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tga decoder assertion failed");

`endif

FILE: src/tgarle_pkg.sv
`default_nettype none

package tgarle_pkg;

    localparam int QUEUE_DEPTH = 4;

    // TGA header byte offsets
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE  = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_ATTR      = 5'd17;

    localparam logic [7:0] KIND_RAW  = 8'd2;
    localparam logic [7:0] KIND_RLE  = 8'd10;
    localparam logic [7:0] MAP_NONE  = 8'd0;
    localparam logic [7:0] BPP_24    = 8'd24;
    localparam logic [7:0] BPP_32    = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam int         ATTR_TOP_BIT = 5;

    localparam logic STATUS_PIXEL    = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_PACKET = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_file;
    } t_in;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic        last_pixel;
        logic        status;
        logic        top_origin;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_out;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

`default_nettype wire

FILE: src/tgarle_parser.sv
`default_nettype none

`include "tga_rle_pixel_decoder_unit_defines.svh"

module tgarle_parser
    import tgarle_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_in  i_data,
    output logic      o_push,
    output t_out      o_res
);

    t_phase      r_phase,     n_phase;
    logic [4:0]  r_hidx,      n_hidx;
    logic [7:0]  r_id_left,   n_id_left;
    logic [7:0]  r_kind,      n_kind;
    logic [7:0]  r_map,       n_map;
    logic [7:0]  r_bpp,       n_bpp;
    logic [7:0]  r_attr,      n_attr;
    logic [15:0] r_width,     n_width;
    logic [15:0] r_height,    n_height;
    logic [31:0] r_pix_left,  n_pix_left;
    logic [7:0]  r_pkt_left,  n_pkt_left;
    logic        r_pkt_rep,   n_pkt_rep;
    logic [1:0]  r_bidx,      n_bidx;
    logic [23:0] r_bytes,     n_bytes;

    logic [7:0]  byte_in;
    logic [7:0]  cnt;
    logic        last_byte;
    logic        last;

    assign byte_in = i_data.in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hidx     <= '0;
            r_id_left  <= '0;
            r_kind     <= '0;
            r_map      <= '0;
            r_bpp      <= '0;
            r_attr     <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_pix_left <= '0;
            r_pkt_left <= '0;
            r_pkt_rep  <= 1'b0;
            r_bidx     <= '0;
            r_bytes    <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_hidx     <= n_hidx;
            r_id_left  <= n_id_left;
            r_kind     <= n_kind;
            r_map      <= n_map;
            r_bpp      <= n_bpp;
            r_attr     <= n_attr;
            r_width    <= n_width;
            r_height   <= n_height;
            r_pix_left <= n_pix_left;
            r_pkt_left <= n_pkt_left;
            r_pkt_rep  <= n_pkt_rep;
            r_bidx     <= n_bidx;
            r_bytes    <= n_bytes;
        end
    end

    // State is worked through in order: restart, then the phase handler.
    always_comb begin
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_id_left  = r_id_left;
        n_kind     = r_kind;
        n_map      = r_map;
        n_bpp      = r_bpp;
        n_attr     = r_attr;
        n_width    = r_width;
        n_height   = r_height;
        n_pix_left = r_pix_left;
        n_pkt_left = r_pkt_left;
        n_pkt_rep  = r_pkt_rep;
        n_bidx     = r_bidx;
        n_bytes    = r_bytes;
        o_push     = 1'b0;
        cnt        = 8'd1;
        last       = 1'b0;
        last_byte  = 1'b0;
        o_res      = '0;

        if (i_data.new_file) begin
            n_phase    = PH_HEADER;
            n_hidx     = '0;
            n_id_left  = '0;
            n_kind     = '0;
            n_map      = '0;
            n_bpp      = '0;
            n_attr     = '0;
            n_width    = '0;
            n_height   = '0;
            n_pix_left = '0;
            n_pkt_left = '0;
            n_pkt_rep  = 1'b0;
            n_bidx     = '0;
            n_bytes    = '0;
        end

        unique case (n_phase)
            PH_HEADER: begin
                unique case (n_hidx)
                    HDR_ID_LEN:    n_id_left = byte_in;
                    HDR_MAP_TYPE:  n_map     = byte_in;
                    HDR_IMG_TYPE:  n_kind    = byte_in;
                    HDR_WIDTH_LO:  n_width   = {n_width[15:8], byte_in};
                    HDR_WIDTH_HI:  n_width   = {byte_in, n_width[7:0]};
                    HDR_HEIGHT_LO: n_height  = {n_height[15:8], byte_in};
                    HDR_HEIGHT_HI: n_height  = {byte_in, n_height[7:0]};
                    HDR_DEPTH:     n_bpp     = byte_in;
                    HDR_ATTR:      n_attr    = byte_in;
                    default: ;
                endcase
                if (n_hidx != HDR_ATTR) begin
                    n_hidx = n_hidx + 5'd1;
                end else begin
                    n_hidx = '0;
                    if ((n_kind != KIND_RAW && n_kind != KIND_RLE) ||
                        (n_bpp != BPP_24 && n_bpp != BPP_32) || n_map != MAP_NONE) begin
                        n_phase      = PH_DONE;
                        o_push       = 1'b1;
                        o_res.status = STATUS_REJECTED;
                    end else begin
                        n_pix_left = {16'd0, n_width} * {16'd0, n_height};
                        if (n_width == '0 || n_height == '0) begin
                            n_phase = PH_DONE;
                        end else if (n_id_left != '0) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_bidx  = '0;
                            n_bytes = '0;
                            if (n_kind == KIND_RLE) begin
                                n_phase = PH_PACKET;
                            end else begin
                                n_pkt_rep  = 1'b0;
                                n_pkt_left = '0;
                                n_phase    = PH_PIXEL;
                            end
                        end
                    end
                end
            end
            PH_SKIP: begin
                n_id_left = n_id_left - 8'd1;
                if (n_id_left == '0) begin
                    n_bidx  = '0;
                    n_bytes = '0;
                    if (n_kind == KIND_RLE) begin
                        n_phase = PH_PACKET;
                    end else begin
                        n_pkt_rep  = 1'b0;
                        n_pkt_left = '0;
                        n_phase    = PH_PIXEL;
                    end
                end
            end
            PH_PACKET: begin
                // raw: low bits + 1; repeat: byte - 127, the same value
                n_pkt_rep  = byte_in[7];
                n_pkt_left = {1'b0, byte_in[6:0]} + 8'd1;
                n_bidx     = '0;
                n_bytes    = '0;
                n_phase    = PH_PIXEL;
            end
            PH_PIXEL: begin
                unique case (n_bidx)
                    2'd0: n_bytes[7:0]   = byte_in;
                    2'd1: n_bytes[15:8]  = byte_in;
                    2'd2: n_bytes[23:16] = byte_in;
                    2'd3: ;
                endcase
                last_byte = (n_bpp == BPP_32) ? (n_bidx == 2'd3) : (n_bidx == 2'd2);
                if (!last_byte) begin
                    n_bidx = n_bidx + 2'd1;
                end else begin
                    o_res.blue  = n_bytes[7:0];
                    o_res.green = n_bytes[15:8];
                    o_res.red   = n_bytes[23:16];
                    o_res.alpha = (n_bpp == BPP_32) ? byte_in : ALPHA_OPAQUE;
                    n_bidx  = '0;
                    n_bytes = '0;
                    if (n_kind == KIND_RLE && n_pkt_rep) begin
                        // clamp the run to what the image still needs
                        cnt = (n_pix_left < {24'd0, n_pkt_left}) ? n_pix_left[7:0]
                                                                  : n_pkt_left;
                        n_pkt_left = '0;
                    end else begin
                        cnt = 8'd1;
                        if (n_pkt_left != '0) begin
                            n_pkt_left = n_pkt_left - 8'd1;
                        end
                    end
                    n_pix_left = n_pix_left - {24'd0, cnt};
                    last       = (n_pix_left == '0);
                    if (last) begin
                        n_phase = PH_DONE;
                    end else if (n_kind == KIND_RLE && n_pkt_left == '0) begin
                        n_phase = PH_PACKET;
                    end
                    o_push             = 1'b1;
                    o_res.repeat_count = cnt;
                    o_res.last_pixel   = last;
                    o_res.status       = STATUS_PIXEL;
                end
            end
            PH_DONE: ;
            default: n_phase = PH_DONE;
        endcase

        o_res.top_origin   = n_attr[ATTR_TOP_BIT];
        o_res.image_width  = n_width;
        o_res.image_height = n_height;
        o_push             = o_push & i_accept;
    end

    `TGA_ASSERT_NEXT(a_reject_ends, i_clk, i_rst_n, o_push && o_res.status, r_phase == PH_DONE)
    `TGA_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_push && o_res.last_pixel, r_phase == PH_DONE)
    `TGA_ASSERT_NOW(a_rep_nonzero, i_clk, i_rst_n, o_push && !o_res.status, o_res.repeat_count != 8'd0)

endmodule

`default_nettype wire

FILE: src/tgarle_queue.sv
`default_nettype none

`include "tga_rle_pixel_decoder_unit_defines.svh"

module tgarle_queue
    import tgarle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_out i_push_data,
    input  wire logic i_pop,
    output t_out      o_pop_data,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_out             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_status.full      = (r_count == CNT_W'(DEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign do_push            = i_push && !o_status.full;
    assign do_pop             = i_pop && o_status.not_empty;
    assign o_pop_data         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `TGA_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_status.full)
    `TGA_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + CNT_W'(1))

endmodule

`default_nettype wire

FILE: src/tgarle_out.sv
`default_nettype none

module tgarle_out
    import tgarle_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q_status,
    input  wire t_out      i_q_data,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out           o_data
);

    logic r_valid, n_valid;
    t_out r_data;

    assign o_pop   = i_q_status.not_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/tga_rle_pixel_decoder_unit.sv
// TGA true-colour decoder: one file byte in per transaction, RGBA pixel results out.
// Input channel: i_in_data carries in_byte and new_file; new_file restarts the
// header parser on that byte. Output channel: o_out_data carries one pixel
// (with its repeat count, last_pixel and header sizes) or a rejected-header
// result with status set.
// Throughput: one byte per cycle while o_in_ready is high; a pixel result
// appears every 3 or 4 bytes (24 or 32 bpp).
// A result is written into the result queue when its final byte is accepted,
// then moves into the output register that drives o_out_valid once that
// register is free.
// ID and packet bytes give no result; a header gives one only if rejected.
// A stalled receiver fills the QDEPTH-entry queue behind the output
// register; o_in_ready then drops until an entry frees up.
// Reset (synchronous, active low) empties the queue and output register and
// returns the parser to header byte zero.
`default_nettype none

module tga_rle_pixel_decoder_unit
    import tgarle_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic      accept;
    logic      push;
    t_out      push_data;
    logic      pop;
    t_out      q_data;
    t_q_status q_status;

    assign o_in_ready = !q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    tgarle_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_push   (push),
        .o_res    (push_data)
    );

    tgarle_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (q_data),
        .o_status    (q_status)
    );

    tgarle_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

`default_nettype wire

FILE: tb/tga_rle_pixel_decoder_unit_test.sv
`timescale 1ns / 100ps

import tgarle_pkg::*;

// Tracks the decoder's parser state byte by byte and holds the pixel
// transactions still owed by the block, oldest first.
class tga_pixel_tracker;
    t_out        pending_pixels[$];
    int          mismatches;
    int          pixels_checked;
    int          rejects_checked;

    t_phase      stage;
    logic [4:0]  hdr_pos;
    logic [7:0]  id_left;
    logic [7:0]  kind;
    logic [7:0]  cmap;
    logic [7:0]  depth;
    logic [7:0]  attr;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic [31:0] remaining;
    logic [7:0]  run_left;
    logic        run_is_repeat;
    logic [1:0]  byte_pos;
    logic [23:0] bgr;

    function new();
        mismatches = 0;
        pixels_checked = 0;
        rejects_checked = 0;
        restart();
    endfunction

    function void restart();
        stage = PH_HEADER;
        hdr_pos = '0;
        id_left = '0;
        kind = '0;
        cmap = '0;
        depth = '0;
        attr = '0;
        wid = '0;
        hgt = '0;
        remaining = '0;
        run_left = '0;
        run_is_repeat = 1'b0;
        byte_pos = '0;
        bgr = '0;
    endfunction

    function void start_image_data();
        byte_pos = '0;
        bgr = '0;
        if (kind == KIND_RLE) begin
            stage = PH_PACKET;
        end else begin
            run_is_repeat = 1'b0;
            run_left = '0;
            stage = PH_PIXEL;
        end
    endfunction

    function void queue_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                               logic [7:0] count, logic last, logic st);
        t_out res;
        res.red = r;
        res.green = g;
        res.blue = b;
        res.alpha = a;
        res.repeat_count = count;
        res.last_pixel = last;
        res.status = st;
        res.top_origin = attr[ATTR_TOP_BIT];
        res.image_width = wid;
        res.image_height = hgt;
        pending_pixels.push_back(res);
    endfunction

    function void byte_accepted(t_in item);
        logic [7:0] value;
        logic       four_bytes;
        logic [7:0] count;
        value = item.in_byte;
        if (item.new_file)
            restart();
        case (stage)
            PH_HEADER: begin
                case (hdr_pos)
                    HDR_ID_LEN:    id_left = value;
                    HDR_MAP_TYPE:  cmap = value;
                    HDR_IMG_TYPE:  kind = value;
                    HDR_WIDTH_LO:  wid[7:0] = value;
                    HDR_WIDTH_HI:  wid[15:8] = value;
                    HDR_HEIGHT_LO: hgt[7:0] = value;
                    HDR_HEIGHT_HI: hgt[15:8] = value;
                    HDR_DEPTH:     depth = value;
                    HDR_ATTR:      attr = value;
                    default: ;
                endcase
                if (hdr_pos != HDR_ATTR) begin
                    hdr_pos++;
                end else begin
                    hdr_pos = '0;
                    if (!(kind == KIND_RAW || kind == KIND_RLE) ||
                        !(depth == BPP_24 || depth == BPP_32) || cmap != MAP_NONE) begin
                        stage = PH_DONE;
                        queue_result('0, '0, '0, '0, '0, 1'b0, STATUS_REJECTED);
                    end else begin
                        remaining = {16'd0, wid} * {16'd0, hgt};
                        if (remaining == 0)
                            stage = PH_DONE;
                        else if (id_left != 0)
                            stage = PH_SKIP;
                        else
                            start_image_data();
                    end
                end
            end
            PH_SKIP: begin
                id_left--;
                if (id_left == 0)
                    start_image_data();
            end
            PH_PACKET: begin
                // raw and repeat headers share the same count encoding in bits 6:0
                run_is_repeat = value[7];
                run_left = {1'b0, value[6:0]} + 8'd1;
                byte_pos = '0;
                bgr = '0;
                stage = PH_PIXEL;
            end
            PH_PIXEL: begin
                four_bytes = (depth == BPP_32);
                if (byte_pos != 2'd3)
                    bgr[8*byte_pos +: 8] = value;
                if (four_bytes ? (byte_pos != 2'd3) : (byte_pos != 2'd2)) begin
                    byte_pos++;
                end else begin
                    byte_pos = '0;
                    if (kind == KIND_RLE && run_is_repeat) begin
                        // repeat run clamped to what is left of the image
                        count = (32'(run_left) > remaining) ? remaining[7:0] : run_left;
                        run_left = '0;
                    end else begin
                        count = 8'd1;
                        if (run_left != 0)
                            run_left--;
                    end
                    remaining -= 32'(count);
                    if (remaining == 0)
                        stage = PH_DONE;
                    else if (kind == KIND_RLE && run_left == 0)
                        stage = PH_PACKET;
                    queue_result(bgr[23:16], bgr[15:8], bgr[7:0],
                                 four_bytes ? value : ALPHA_OPAQUE, count,
                                 remaining == 0, STATUS_PIXEL);
                    bgr = '0;
                end
            end
            default: stage = PH_DONE;
        endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void pixel_seen(t_out got);
        t_out want;
        if (pending_pixels.size() == 0) begin
            $error("result transaction with nothing expected: %h", got);
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("red", want.red, got.red);
        compare_field("green", want.green, got.green);
        compare_field("blue", want.blue, got.blue);
        compare_field("alpha", want.alpha, got.alpha);
        compare_field("repeat_count", want.repeat_count, got.repeat_count);
        compare_field("last_pixel", want.last_pixel, got.last_pixel);
        compare_field("status", want.status, got.status);
        compare_field("top_origin", want.top_origin, got.top_origin);
        compare_field("image_width", want.image_width, got.image_width);
        compare_field("image_height", want.image_height, got.image_height);
        if (want.status == STATUS_REJECTED)
            rejects_checked++;
        else
            pixels_checked++;
    endfunction
endclass

module tga_rle_pixel_decoder_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1850;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out out_data;

    tga_pixel_tracker tracker;
    int   cycles      = 0;
    int   bytes_sent  = 0;
    int   files_sent  = 0;
    bit   sender_calm = 1'b0;
    bit   sink_calm   = 1'b0;
    logic [7:0] file_buf[$];

    tga_rle_pixel_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tga_rle_pixel_decoder_unit test failed");
            $finish;
        end
    end

    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'($urandom_range(0, 65535));
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 7));
        endcase
    endfunction

    function automatic logic [7:0] pick_id_len();
        int r = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(1, 255));
        if (r < 5)
            return 8'($urandom_range(1, 3));
        return 8'd0;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic restart);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in'{in_byte: value, new_file: restart};
        do @(posedge i_clk); while (!o_in_ready);
        tracker.byte_accepted(in_data);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_buf[i])
            send_byte(file_buf[i], i == 0);
        files_sent++;
    endtask

    // header then ID field; unused header bytes get random filler
    task automatic put_header(input logic [7:0] id_len, input logic [7:0] cmap,
                              input logic [7:0] kind, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth,
                              input logic [7:0] attr);
        file_buf.delete();
        for (int i = 0; i <= HDR_ATTR; i++) begin
            case (5'(i))
                HDR_ID_LEN:    file_buf.push_back(id_len);
                HDR_MAP_TYPE:  file_buf.push_back(cmap);
                HDR_IMG_TYPE:  file_buf.push_back(kind);
                HDR_WIDTH_LO:  file_buf.push_back(w[7:0]);
                HDR_WIDTH_HI:  file_buf.push_back(w[15:8]);
                HDR_HEIGHT_LO: file_buf.push_back(h[7:0]);
                HDR_HEIGHT_HI: file_buf.push_back(h[15:8]);
                HDR_DEPTH:     file_buf.push_back(depth);
                HDR_ATTR:      file_buf.push_back(attr);
                default:       file_buf.push_back(rnd_byte());
            endcase
        end
        repeat (id_len) file_buf.push_back(rnd_byte());
    endtask

    task automatic put_pixels(input int count, input logic [7:0] depth);
        repeat (count * ((depth == BPP_32) ? 4 : 3)) file_buf.push_back(rnd_byte());
    endtask

    task automatic put_body(input logic [7:0] kind, input logic [7:0] depth, input int target);
        int covered;
        int n;
        covered = 0;
        if (kind != KIND_RLE) begin
            put_pixels(target, depth);
        end else begin
            while (covered < target) begin
                if ($urandom_range(0, 1)) begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
                                                    : $urandom_range(1, 4);
                    file_buf.push_back({1'b1, 7'(n - 1)});
                    put_pixels(1, depth);
                end else begin
                    n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40)
                                                     : $urandom_range(1, 4);
                    file_buf.push_back({1'b0, 7'(n - 1)});
                    put_pixels(n, depth);
                end
                covered += n;
            end
        end
    endtask

    task automatic build_rejected();
        logic [7:0] kind;
        logic [7:0] depth;
        logic [7:0] cmap;
        kind  = $urandom_range(0, 1) ? KIND_RAW : KIND_RLE;
        depth = $urandom_range(0, 1) ? BPP_24 : BPP_32;
        cmap  = MAP_NONE;
        case ($urandom_range(0, 2))
            0:       do kind = rnd_byte(); while (kind == KIND_RAW || kind == KIND_RLE);
            1:       do depth = rnd_byte(); while (depth == BPP_24 || depth == BPP_32);
            default: cmap = 8'($urandom_range(1, 255));
        endcase
        put_header(pick_id_len(), cmap, kind, pick_dim(), pick_dim(), depth, rnd_byte());
        repeat ($urandom_range(0, 5)) file_buf.push_back(rnd_byte());
    endtask

    task automatic build_image();
        logic [7:0]  kind;
        logic [7:0]  depth;
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] area;
        int          target;
        kind  = $urandom_range(0, 1) ? KIND_RAW : KIND_RLE;
        depth = $urandom_range(0, 1) ? BPP_24 : BPP_32;
        w     = pick_dim();
        h     = pick_dim();
        area  = {16'd0, w} * {16'd0, h};
        // big images are cut short; the next file restarts the parser
        target = (area > 40) ? $urandom_range(1, 40) : int'(area);
        if ($urandom_range(0, 9) == 0)
            target = $urandom_range(0, target);
        put_header(pick_id_len(), MAP_NONE, kind, w, h, depth, rnd_byte());
        put_body(kind, depth, target);
        repeat ($urandom_range(0, 3)) file_buf.push_back(rnd_byte());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 16))
            send_byte(rnd_byte(), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.pixel_seen(out_data);
            if ($urandom_range(0, 15) == 0)
                sink_calm = !sink_calm;
        end
    end

    initial begin
        int pick;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 32 bpp RLE with ID field and top origin; repeat run of 128 clamped to 4
        put_header(8'd2, MAP_NONE, KIND_RLE, 16'd2, 16'd2, BPP_32, 8'h20);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'hAA);
        file_buf.push_back(8'h55);
        send_file();

        // uncompressed 24 bpp
        put_header(8'd0, MAP_NONE, KIND_RAW, 16'd3, 16'd1, BPP_24, 8'h00);
        repeat (3) file_buf.push_back(8'hFF);
        repeat (3) file_buf.push_back(8'h00);
        file_buf.push_back(8'h12);
        file_buf.push_back(8'h34);
        file_buf.push_back(8'h56);
        send_file();

        // raw packet of 128 against a two pixel image
        put_header(8'd0, MAP_NONE, KIND_RLE, 16'd1, 16'd2, BPP_24, 8'hDF);
        file_buf.push_back(8'h7F);
        put_pixels(4, BPP_24);
        send_file();

        // rejected: bad type, bad depth, colour map present
        put_header(8'd0, MAP_NONE, 8'd1, 16'd1, 16'd1, BPP_24, 8'h20);
        file_buf.push_back(8'h11);
        send_file();
        put_header(8'd0, MAP_NONE, KIND_RAW, 16'd1, 16'd1, 8'd16, 8'h00);
        file_buf.push_back(8'h22);
        send_file();
        put_header(8'd0, 8'd1, KIND_RLE, 16'd1, 16'd1, BPP_32, 8'h00);
        send_file();

        // empty images, trailing bytes ignored
        put_header(8'd0, MAP_NONE, KIND_RAW, 16'd0, 16'd5, BPP_24, 8'h00);
        repeat (3) file_buf.push_back(rnd_byte());
        send_file();
        put_header(8'd0, MAP_NONE, KIND_RLE, 16'd5, 16'd0, BPP_32, 8'h00);
        repeat (3) file_buf.push_back(rnd_byte());
        send_file();

        // largest sizes, truncated after a few packets
        put_header(8'd0, MAP_NONE, KIND_RLE, 16'hFFFF, 16'hFFFF, BPP_32, 8'hFF);
        file_buf.push_back(8'hFF);
        put_pixels(1, BPP_32);
        file_buf.push_back(8'h00);
        put_pixels(1, BPP_32);
        file_buf.push_back(8'h80);
        put_pixels(1, BPP_32);
        send_file();

        // longest ID field
        put_header(8'd255, MAP_NONE, KIND_RAW, 16'd1, 16'd1, BPP_32, 8'h00);
        put_pixels(1, BPP_32);
        send_file();

        while (bytes_sent < ITEM_TARGET) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_noise();
            end else if (pick < 16) begin
                build_rejected();
                send_file();
            end else begin
                build_image();
                send_file();
            end
        end
        in_valid <= 1'b0;

        while (tracker.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Decoded %0d files (%0d bytes, noise and truncated files included).",
                 files_sent, bytes_sent);
        $display("Checked %0d pixel transactions and %0d rejected headers.",
                 tracker.pixels_checked, tracker.rejects_checked);
        if (tracker.mismatches == 0)
            $display("tga_rle_pixel_decoder_unit test passed");
        else
            $display("tga_rle_pixel_decoder_unit test failed");
        $finish;
    end

endmodule
